@@ src/tcdp_pkg.sv @@
package tcdp_pkg;

  // fixed field widths
  localparam int ENTRY_W = 5;
  localparam int WORD_W = 8;
  localparam int ACT_W = 16;
  localparam int SCALE_W = 16;
  localparam int TERM_W = ACT_W + 1;
  localparam int BSUM_W = 24;
  localparam int TOTAL_W = 64;
  localparam int IN_LANES = 4;
  localparam int MAX_LANES = 5;

  // request packing on the slave side
  localparam int ENTRY_LSB = 0;
  localparam int WORD_LSB = ENTRY_LSB + ENTRY_W;
  localparam int ACT_LSB = WORD_LSB + WORD_W;
  localparam int SCALE_LSB = ACT_LSB + IN_LANES * ACT_W;
  localparam int IN_BITS = SCALE_LSB + SCALE_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_W = 2;
  localparam int TUSER_FUNC = 0;
  localparam int TUSER_BLOCK_END = 1;

  // func codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_ACCUM = 1'b1;

  // stored base-3 digit codes, weight is digit minus one
  localparam logic [1:0] TRIT_NEG = 2'd0;
  localparam logic [1:0] TRIT_ZERO = 2'd1;
  localparam logic [1:0] TRIT_POS = 2'd2;

  localparam int BSUM_MAX = 8388607;
  localparam int BSUM_MIN = -8388608;

  // fp16 fields
  localparam int FP_MAN_W = 10;
  localparam int FP_EXP_W = 5;
  localparam logic [FP_EXP_W-1:0] FP_EXP_SPECIAL = 5'h1F;
  localparam logic [FP_EXP_W-1:0] FP_EXP_BIAS_SHIFT = 5'd13;
  localparam int SIG_W = FP_MAN_W + 1;
  localparam int PROD_W = BSUM_W + SIG_W;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CONTRIB_NONE,
    CONTRIB_ADD,
    CONTRIB_SET
  } contrib_op_t;

  typedef struct packed {
    logic                 valid;
    logic                 in_range;
    logic                 block_end;
    logic                 row_end;
    logic [SCALE_W-1:0]   scale;
  } grp_ctl_t;

  typedef struct packed {
    logic                      valid;
    logic                      finish;
    logic                      row_end;
    logic                      ovf;
    logic signed [BSUM_W-1:0]  bsum;
    logic [SCALE_W-1:0]        scale;
  } blk_t;

  typedef struct packed {
    logic                       valid;
    logic                       row_end;
    logic                       ovf;
    contrib_op_t                op;
    logic signed [TOTAL_W-1:0]  value;
  } contrib_t;

  // base-3 digits of a byte, lowest first; divide by 3 as (r * 171) >> 9
  function automatic logic [2*MAX_LANES-1:0] trit_digits(input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] r;
    logic [15:0]       p;
    logic [WORD_W-1:0] q;
    logic [WORD_W-1:0] d;
    logic [2*MAX_LANES-1:0] res;
    r = b;
    res = '0;
    for (int k = 0; k < MAX_LANES; k++) begin
      p = {8'd0, r} * 16'd171;
      q = {1'b0, p[15:9]};
      d = r - 8'(q * 8'd3);
      res[2*k +: 2] = d[1:0];
      r = q;
    end
    return res;
  endfunction

endpackage

@@ src/ternary_codebook_dot_product.sv @@
// Ternary codebook dot product over a stream of groups.
// Slave channel s_axis_*: one request is either a codebook load (tuser func = 0),
// which stores the base-3 weights of table_word in the named entry, or a group
// (func = 1) of four Q4.12 activations weighted by a stored entry. tuser block_end
// closes a block: its sum is scaled by the fp16 scale_bits and added into a
// saturating Q39.24 row total. tlast closes the row and emits one result.
// Master channel m_axis_*: dot_total in tdata, overflow_flag in tuser.
// Throughput: one request per cycle while s_axis_tready is high. The path from an
// accepted request to the output register runs codebook read, lane weighting, block
// sum, scale multiply, alignment, total update.
// When the receiver stalls, requests keep flowing until a second row end
// reaches the total stage; only then is s_axis_tready dropped.
// Reset clears block sum, row total, the overflow flag and all valid bits;
// the codebook keeps its contents and must be loaded before use.
module ternary_codebook_dot_product #(
  parameter int CODEBOOK_ENTRIES = 32,
  parameter int LANES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // entry, table_word, act_lane0..act_lane3, scale_bits, zero fill
  input  logic [tcdp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // func, block_end
  input  logic [tcdp_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // dot_total
  output logic [tcdp_pkg::TOTAL_W-1:0]        m_axis_tdata,
  // overflow_flag
  output logic [0:0]                          m_axis_tuser
);
  import tcdp_pkg::*;

  localparam int AW = $clog2(CODEBOOK_ENTRIES);
  localparam int WW = 2 * LANES;

  logic                  en;
  logic                  accept;
  logic                  func;
  logic [ENTRY_W-1:0]    entry;
  logic [WORD_W-1:0]     table_word;
  logic                  in_range;
  logic [AW-1:0]         addr;
  logic [2*MAX_LANES-1:0] digits_all;
  logic [WW-1:0]         weights;

  grp_ctl_t              s1_ctl;
  grp_ctl_t              s1_ctl_next;
  grp_ctl_t              s2_ctl;
  logic signed [ACT_W-1:0] s1_act [IN_LANES];
  logic signed [TERM_W-1:0] terms [LANES];
  blk_t                  blk;
  contrib_t              contrib;

  logic signed [TOTAL_W-1:0] row_total;
  logic                      sticky_overflow;
  logic signed [TOTAL_W:0]   sum_wide;
  logic signed [TOTAL_W-1:0] total_next;
  logic                      ovf_next;

  assign en = !(contrib.valid && contrib.row_end && m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = en;
  assign accept = s_axis_tvalid && en;

  assign func = s_axis_tuser[TUSER_FUNC];
  assign entry = s_axis_tdata[ENTRY_LSB +: ENTRY_W];
  assign table_word = s_axis_tdata[WORD_LSB +: WORD_W];
  assign in_range = 32'(entry) < CODEBOOK_ENTRIES;
  assign addr = AW'(entry);
  assign digits_all = trit_digits(table_word);

  tcdp_ram #(
    .WIDTH (WW),
    .DEPTH (CODEBOOK_ENTRIES)
  ) u_codebook (
    .clk   (clk),
    .we    (accept && func == FUNC_LOAD && in_range),
    .waddr (addr),
    .wdata (digits_all[WW-1:0]),
    .re    (accept && func == FUNC_ACCUM),
    .raddr (addr),
    .rdata (weights)
  );

  always_comb begin
    s1_ctl_next.valid = accept && func == FUNC_ACCUM;
    s1_ctl_next.in_range = in_range;
    s1_ctl_next.block_end = s_axis_tuser[TUSER_BLOCK_END];
    s1_ctl_next.row_end = s_axis_tlast;
    s1_ctl_next.scale = s_axis_tdata[SCALE_LSB +: SCALE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
      s2_ctl.valid <= 1'b0;
    end else if (en) begin
      s1_ctl <= s1_ctl_next;
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < IN_LANES; i++) begin
        s1_act[i] <= s_axis_tdata[ACT_LSB + i*ACT_W +: ACT_W];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    if (g < IN_LANES) begin : g_act
      tcdp_lane u_lane (
        .clk      (clk),
        .en       (en),
        .in_range (s1_ctl.in_range),
        .digit    (weights[2*g +: 2]),
        .act      (s1_act[g]),
        .term     (terms[g])
      );
    end else begin : g_idle
      // lanes past the fourth have no activation field
      tcdp_lane u_lane (
        .clk      (clk),
        .en       (en),
        .in_range (s1_ctl.in_range),
        .digit    (weights[2*g +: 2]),
        .act      ('0),
        .term     (terms[g])
      );
    end
  end

  tcdp_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .ctl   (s2_ctl),
    .terms (terms),
    .blk   (blk)
  );

  tcdp_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .blk     (blk),
    .contrib (contrib)
  );

  always_comb begin
    sum_wide = {row_total[TOTAL_W-1], row_total} + {contrib.value[TOTAL_W-1], contrib.value};
    total_next = row_total;
    ovf_next = sticky_overflow | contrib.ovf;
    unique case (contrib.op)
      CONTRIB_ADD: begin
        if (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1]) begin
          total_next = sum_wide[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
          ovf_next = 1'b1;
        end else begin
          total_next = sum_wide[TOTAL_W-1:0];
        end
      end
      CONTRIB_SET: total_next = contrib.value;
      default:     total_next = row_total;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_total <= '0;
      sticky_overflow <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (en && contrib.valid && contrib.row_end) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= total_next;
        m_axis_tuser <= ovf_next;
        row_total <= '0;
        sticky_overflow <= 1'b0;
      end else begin
        if (m_axis_tvalid && m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
        end
        if (en && contrib.valid) begin
          row_total <= total_next;
          sticky_overflow <= ovf_next;
        end
      end
    end
  end

endmodule

@@ src/tcdp_ram.sv @@
module tcdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/tcdp_lane.sv @@
module tcdp_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              in_range,
  input  logic [1:0]                        digit,
  input  logic signed [tcdp_pkg::ACT_W-1:0] act,
  output logic signed [tcdp_pkg::TERM_W-1:0] term
);
  import tcdp_pkg::*;

  logic signed [TERM_W-1:0] term_next;

  always_comb begin
    term_next = '0;
    if (in_range) begin
      unique case (digit)
        TRIT_NEG: term_next = -TERM_W'(act);
        TRIT_POS: term_next = TERM_W'(act);
        default:  term_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term <= term_next;
    end
  end

endmodule

@@ src/tcdp_merge.sv @@
module tcdp_merge #(
  parameter int LANES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  tcdp_pkg::grp_ctl_t                  ctl,
  input  logic signed [tcdp_pkg::TERM_W-1:0]  terms [LANES],
  output tcdp_pkg::blk_t                      blk
);
  import tcdp_pkg::*;

  localparam int GSUM_W = TERM_W + $clog2(LANES + 1);
  localparam int NB_W = ((GSUM_W > BSUM_W) ? GSUM_W : BSUM_W) + 1;
  localparam logic signed [NB_W-1:0] SAT_HI = NB_W'(BSUM_MAX);
  localparam logic signed [NB_W-1:0] SAT_LO = NB_W'(BSUM_MIN);

  logic signed [BSUM_W-1:0] bsum_acc;
  logic signed [BSUM_W-1:0] bs_new;
  logic signed [GSUM_W-1:0] gsum;
  logic signed [NB_W-1:0]   nb;
  logic                     sat;
  blk_t                     blk_next;

  always_comb begin
    gsum = '0;
    for (int i = 0; i < LANES; i++) begin
      gsum = gsum + GSUM_W'(terms[i]);
    end
    nb = NB_W'(bsum_acc) + NB_W'(gsum);
    sat = 1'b0;
    if (nb > SAT_HI) begin
      bs_new = BSUM_W'(SAT_HI);
      sat = 1'b1;
    end else if (nb < SAT_LO) begin
      bs_new = BSUM_W'(SAT_LO);
      sat = 1'b1;
    end else begin
      bs_new = BSUM_W'(nb);
    end
    blk_next.valid = ctl.valid;
    blk_next.finish = ctl.block_end;
    blk_next.row_end = ctl.row_end;
    blk_next.ovf = sat;
    blk_next.bsum = bs_new;
    blk_next.scale = ctl.scale;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bsum_acc <= '0;
      blk.valid <= 1'b0;
    end else if (en) begin
      blk <= blk_next;
      if (ctl.valid) begin
        // the block sum always restarts after a block or a row
        bsum_acc <= (ctl.block_end || ctl.row_end) ? '0 : bs_new;
      end
    end
  end

endmodule

@@ src/tcdp_scale.sv @@
module tcdp_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  tcdp_pkg::blk_t      blk,
  output tcdp_pkg::contrib_t  contrib
);
  import tcdp_pkg::*;

  // first stage: classify scale and multiply magnitudes
  logic                  sgn;
  logic [FP_EXP_W-1:0]   ex;
  logic [FP_MAN_W-1:0]   man;
  logic [SIG_W-1:0]      sig;
  logic [FP_EXP_W-1:0]   ex_eff;
  logic [BSUM_W-1:0]     mag;
  contrib_op_t           op_next;
  logic                  ovf_next;

  logic                  p_valid;
  logic                  p_row_end;
  logic                  p_ovf;
  contrib_op_t           p_op;
  logic                  p_neg;
  logic [FP_EXP_W-1:0]   p_exp;
  logic [PROD_W-1:0]     p_prod;

  // second stage: align to Q39.24 with rounding
  logic [TOTAL_W-1:0]    wide;
  logic [TOTAL_W-1:0]    shifted;
  logic [3:0]            rsh;
  logic [FP_EXP_W-1:0]   lsh;
  contrib_t              contrib_next;

  always_comb begin
    sgn = blk.scale[SCALE_W-1];
    ex = blk.scale[FP_MAN_W +: FP_EXP_W];
    man = blk.scale[FP_MAN_W-1:0];
    sig = (ex == '0) ? {1'b0, man} : {1'b1, man};
    ex_eff = (ex == '0) ? FP_EXP_W'(1) : ex;
    mag = blk.bsum[BSUM_W-1] ? BSUM_W'(-blk.bsum) : BSUM_W'(blk.bsum);
    ovf_next = blk.ovf;
    op_next = CONTRIB_NONE;
    if (blk.finish) begin
      if (ex == FP_EXP_SPECIAL) begin
        ovf_next = 1'b1;
        // infinity on a nonzero block sum forces the total, nan leaves it alone
        if (man == '0 && blk.bsum != '0) begin
          op_next = CONTRIB_SET;
        end
      end else if (!(ex == '0 && man == '0)) begin
        op_next = CONTRIB_ADD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= blk.valid;
      p_row_end <= blk.row_end;
      p_ovf <= ovf_next;
      p_op <= op_next;
      p_neg <= sgn ^ blk.bsum[BSUM_W-1];
      p_exp <= ex_eff;
      p_prod <= PROD_W'(mag) * PROD_W'(sig);
    end
  end

  always_comb begin
    wide = TOTAL_W'(p_prod);
    lsh = p_exp - FP_EXP_BIAS_SHIFT;
    rsh = 4'(FP_EXP_BIAS_SHIFT - p_exp);
    if (p_exp >= FP_EXP_BIAS_SHIFT) begin
      shifted = wide << lsh;
    end else begin
      // round half away from zero on the magnitude
      shifted = (wide + (TOTAL_W'(1) << (rsh - 4'd1))) >> rsh;
    end
    contrib_next.valid = p_valid;
    contrib_next.row_end = p_row_end;
    contrib_next.ovf = p_ovf;
    contrib_next.op = p_op;
    if (p_op == CONTRIB_SET) begin
      contrib_next.value = p_neg ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      contrib_next.value = p_neg ? -$signed(shifted) : $signed(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      contrib.valid <= 1'b0;
    end else if (en) begin
      contrib <= contrib_next;
    end
  end

endmodule

@@ sim/ternary_codebook_dot_product_test.sv @@
`timescale 1ns / 100ps

module ternary_codebook_dot_product_test;
  import tcdp_pkg::*;

  localparam int RUN_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;
  localparam int IDLE_PCT = 12;
  localparam int HOLD_AT = 350;
  localparam int HOLD_CYCLES = 200;
  localparam int CALM_FROM = 500;
  localparam int CALM_TO = 650;
  localparam logic [WORD_W-1:0] WORD_ALL_NEG = 8'd0;
  localparam logic [WORD_W-1:0] WORD_ALL_ZERO = 8'd40;
  localparam logic [WORD_W-1:0] WORD_ALL_POS = 8'd80;

  typedef struct packed {
    logic                             drain_first;
    logic                             func;
    logic [ENTRY_W-1:0]               entry;
    logic [WORD_W-1:0]                word;
    logic [IN_LANES-1:0][ACT_W-1:0]   act;
    logic [SCALE_W-1:0]               scale;
    logic                             block_end;
    logic                             row_end;
  } tcdp_req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               ovf;
  } row_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TOTAL_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  ternary_codebook_dot_product DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  tcdp_req_t pending_reqs[$];
  row_result_t expected_rows[$];
  tcdp_req_t on_bus;
  bit req_taken = 1'b0;
  int reqs_accepted = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int sink_hold = 0;
  bit sink_hold_done = 1'b0;

  // generator side
  int gen_loaded[$];
  int gen_rows = 0;

  // predictor state
  logic [WORD_W-1:0] cb_model [32];
  int bsum_model = 0;
  logic signed [TOTAL_W-1:0] total_model = '0;
  bit ovf_model = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit calm_window();
    return reqs_accepted >= CALM_FROM && reqs_accepted < CALM_TO;
  endfunction

  // ---------------- predictor ----------------

  task automatic add_into_total(input logic signed [TOTAL_W-1:0] c);
    logic signed [TOTAL_W:0] wide;
    wide = {total_model[TOTAL_W-1], total_model} + {c[TOTAL_W-1], c};
    if (wide[TOTAL_W] != wide[TOTAL_W-1]) begin
      total_model = wide[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
      ovf_model = 1'b1;
    end else begin
      total_model = wide[TOTAL_W-1:0];
    end
  endtask

  task automatic scale_block(input logic [SCALE_W-1:0] sc);
    logic [FP_EXP_W-1:0] ex;
    logic [FP_MAN_W-1:0] man;
    logic [SIG_W-1:0] sig;
    longint b;
    logic [63:0] mag;
    int sh;
    bit neg;
    ex = sc[FP_MAN_W +: FP_EXP_W];
    man = sc[FP_MAN_W-1:0];
    neg = sc[SCALE_W-1] ^ (bsum_model < 0);
    if (ex == FP_EXP_SPECIAL) begin
      ovf_model = 1'b1;
      if (man == '0 && bsum_model != 0)
        total_model = neg ? TOTAL_MIN : TOTAL_MAX;
      return;
    end
    if (ex == '0 && man == '0)
      return;
    if (ex == '0) begin
      sig = {1'b0, man};
      sh = 1 - int'(FP_EXP_BIAS_SHIFT);
    end else begin
      sig = {1'b1, man};
      sh = int'(ex) - int'(FP_EXP_BIAS_SHIFT);
    end
    b = bsum_model;
    mag = 64'(b < 0 ? -b : b) * 64'(sig);
    if (sh >= 0)
      mag = mag << sh;
    else
      mag = (mag + (64'd1 << (-sh - 1))) >> (-sh);
    add_into_total(neg ? -$signed(mag) : $signed(mag));
  endtask

  task automatic predict_request(input tcdp_req_t r);
    logic [WORD_W-1:0] w;
    logic [1:0] d;
    int gsum;
    int nb;
    row_result_t res;
    if (r.func == FUNC_LOAD) begin
      cb_model[r.entry] = r.word;
      return;
    end
    gsum = 0;
    w = cb_model[r.entry];
    for (int lane = 0; lane < IN_LANES; lane++) begin
      d = 2'(w % 3);
      w = w / 3;
      if (d == TRIT_NEG)
        gsum -= int'($signed(r.act[lane]));
      else if (d == TRIT_POS)
        gsum += int'($signed(r.act[lane]));
    end
    nb = bsum_model + gsum;
    if (nb > BSUM_MAX) begin
      nb = BSUM_MAX;
      ovf_model = 1'b1;
    end else if (nb < BSUM_MIN) begin
      nb = BSUM_MIN;
      ovf_model = 1'b1;
    end
    bsum_model = nb;
    if (r.block_end) begin
      scale_block(r.scale);
      bsum_model = 0;
    end
    if (r.row_end) begin
      res.total = total_model;
      res.ovf = ovf_model;
      expected_rows.push_back(res);
      total_model = '0;
      ovf_model = 1'b0;
      bsum_model = 0;
    end
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic logic [ACT_W-1:0] rand_act();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    logic s;
    s = 1'($urandom);
    case ($urandom_range(0, 11))
      0: return {s, 15'h0000};
      1: return {s, 5'h00, 10'($urandom_range(1, 1023))};
      2: return {s, FP_EXP_SPECIAL, 10'h000};
      3: return {s, FP_EXP_SPECIAL, 10'($urandom_range(1, 1023))};
      4: return {s, 5'($urandom_range(10, 16)), 10'($urandom)};
      5: return {s, 5'd30, 10'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic note_loaded(input int e);
    foreach (gen_loaded[i])
      if (gen_loaded[i] == e) return;
    gen_loaded.push_back(e);
  endtask

  task automatic push_load(input int e, input logic [WORD_W-1:0] w, input bit noisy);
    tcdp_req_t r;
    r = '0;
    r.func = FUNC_LOAD;
    r.entry = ENTRY_W'(e);
    r.word = w;
    if (noisy) begin
      // fields a load ignores still carry random bits
      for (int lane = 0; lane < IN_LANES; lane++) r.act[lane] = rand_act();
      r.scale = 16'($urandom);
      r.block_end = 1'($urandom);
      r.row_end = 1'($urandom);
    end
    pending_reqs.push_back(r);
    note_loaded(e);
  endtask

  task automatic push_group(input int e, input logic [IN_LANES-1:0][ACT_W-1:0] a,
                            input logic [SCALE_W-1:0] sc, input bit be, input bit re,
                            input bit drain);
    tcdp_req_t r;
    r.drain_first = drain;
    r.func = FUNC_ACCUM;
    r.entry = ENTRY_W'(e);
    r.word = 8'($urandom);
    r.act = a;
    r.scale = be ? sc : 16'($urandom);
    r.block_end = be;
    r.row_end = re;
    pending_reqs.push_back(r);
    if (re) gen_rows++;
  endtask

  task automatic build_directed();
    logic [IN_LANES-1:0][ACT_W-1:0] a;
    push_load(0, WORD_ALL_NEG, 0);
    push_load(31, WORD_ALL_POS, 0);
    push_load(1, WORD_ALL_ZERO, 0);
    push_load(2, 8'hFF, 0);
    push_load(3, 8'h5B, 1);
    // largest positive and negative single groups at unit scale
    push_group(31, {4{16'h7FFF}}, 16'h3C00, 1, 1, 0);
    push_group(0, {4{16'h8000}}, 16'h3C00, 1, 1, 0);
    push_group(31, {4{16'h8000}}, 16'hBC00, 1, 1, 0);
    // smallest subnormal, negative zero, then row end inside a block
    a = {16'h1234, 16'h8001, 16'h7FFF, 16'hFFFF};
    push_group(2, a, 16'h0001, 1, 0, 0);
    push_group(31, a, 16'h8000, 1, 0, 0);
    push_group(3, a, 16'h0000, 0, 1, 0);
    // infinity drives the total to a rail, a later add saturates
    push_group(31, {4{16'h7FFF}}, 16'h7C00, 1, 0, 0);
    push_group(31, {4{16'h7FFF}}, 16'h3C00, 1, 1, 0);
    push_group(31, {4{16'h7FFF}}, 16'hFC00, 1, 0, 0);
    push_group(31, {4{16'h7FFF}}, 16'hBC00, 1, 1, 0);
    // infinity on a zero block sum leaves the total
    push_group(1, {4{16'h7FFF}}, 16'h7C00, 1, 1, 0);
    // nan
    push_group(31, {4{16'h0100}}, 16'h7E00, 1, 1, 0);
    push_group(31, {4{16'h0100}}, 16'hFFFF, 1, 1, 0);
    // largest finite scale, both signs
    push_group(0, {4{16'h8000}}, 16'h7BFF, 1, 0, 0);
    push_group(31, {4{16'h8000}}, 16'hFBFF, 1, 1, 0);
    // subnormal with rounding
    push_group(31, {16'h0000, 16'h0000, 16'h0000, 16'h0003}, 16'h03FF, 1, 1, 0);
  endtask

  task automatic build_random();
    logic [IN_LANES-1:0][ACT_W-1:0] a;
    logic [ACT_W-1:0] hot_act;
    int nblk;
    int ngrp;
    int e;
    bit hot;
    bit be;
    bit re;
    bit drain;
    bit first_row;
    first_row = 1'b1;
    while (pending_reqs.size() < 900 || gen_rows < 40) begin
      if ($urandom_range(0, 99) < 15) begin
        push_load($urandom_range(0, 31), 8'($urandom), 1);
      end else begin
        nblk = $urandom_range(1, 3);
        drain = first_row || ($urandom_range(0, 49) == 0);
        first_row = 1'b0;
        for (int b = 0; b < nblk; b++) begin
          hot = ($urandom_range(0, 49) == 0);
          if (hot) begin
            // long block of extreme lanes, drives the block sum past its rails
            ngrp = 70;
            e = $urandom_range(0, 31);
            push_load(e, $urandom_range(0, 1) ? WORD_ALL_POS : WORD_ALL_NEG, 0);
            hot_act = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          end else begin
            ngrp = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 4);
            hot_act = '0;
          end
          for (int g = 0; g < ngrp; g++) begin
            if (!hot) e = gen_loaded[$urandom_range(0, gen_loaded.size() - 1)];
            for (int lane = 0; lane < IN_LANES; lane++)
              a[lane] = hot ? hot_act : rand_act();
            be = (g == ngrp - 1);
            re = be && (b == nblk - 1);
            if (re && $urandom_range(0, 9) == 0) be = 1'b0;
            push_group(e, a, rand_scale(), be, re, drain);
            drain = 1'b0;
          end
        end
      end
    end
  endtask

  // ---------------- driver ----------------

  always @(negedge clk) begin
    logic [IN_TDATA_W-1:0] bus;
    bit gap;
    bit blocked;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      gap = !calm_window() && ($urandom_range(0, 99) < IDLE_PCT);
      blocked = pending_reqs.size() == 0 ||
                (pending_reqs[0].drain_first && expected_rows.size() != 0);
      if (!gap && !blocked) begin
        on_bus = pending_reqs.pop_front();
        bus = '0;
        bus[ENTRY_LSB +: ENTRY_W] = on_bus.entry;
        bus[WORD_LSB +: WORD_W] = on_bus.word;
        bus[ACT_LSB +: IN_LANES*ACT_W] = on_bus.act;
        bus[SCALE_LSB +: SCALE_W] = on_bus.scale;
        s_axis_tdata <= bus;
        s_axis_tuser <= {on_bus.block_end, on_bus.func};
        s_axis_tlast <= on_bus.row_end;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (!sink_hold_done && reqs_accepted >= HOLD_AT) begin
      // long back-pressure so the block fills and stalls its input
      m_axis_tready <= 1'b0;
      sink_hold <= HOLD_CYCLES;
      sink_hold_done <= 1'b1;
    end else begin
      m_axis_tready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------- predict and check ----------------

  always @(posedge clk) begin
    row_result_t want;
    req_taken = !rst && s_axis_tvalid && s_axis_tready;
    if (req_taken) begin
      predict_request(on_bus);
      reqs_accepted++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_rows.size() == 0) begin
        $error("dot_total: unexpected result, actual %0d", $signed(m_axis_tdata));
        mismatches++;
      end else begin
        want = expected_rows.pop_front();
        if (m_axis_tdata !== want.total) begin
          $error("dot_total mismatch: expected %0d, actual %0d",
                 $signed(want.total), $signed(m_axis_tdata));
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.ovf) begin
          $error("overflow_flag mismatch: expected %0b, actual %0b", want.ovf, m_axis_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ternary_codebook_dot_product_test: FAIL");
    $finish;
  end

  initial begin
    build_directed();
    build_random();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_rows.size() == 0)
      $display("ternary_codebook_dot_product_test: PASS");
    else
      $display("ternary_codebook_dot_product_test: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
src/tcdp_pkg.sv
src/tcdp_ram.sv
src/tcdp_lane.sv
src/tcdp_merge.sv
src/tcdp_scale.sv
src/ternary_codebook_dot_product.sv
sim/ternary_codebook_dot_product_test.sv
